>>> rtl/core/stick_arming_controller_defines.svh
// Assertion helpers for the stick arming controller checks.
`ifndef STICK_ARMING_CONTROLLER_DEFINES_SVH
`define STICK_ARMING_CONTROLLER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SAC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stick_arming_controller: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SAC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stick_arming_controller: next-cycle check failed");

`endif

>>> rtl/core/sac_pkg.sv
package sac_pkg;

	localparam int unsigned CH_W  = 12;
	localparam int unsigned SF_W  = 9;
	localparam int unsigned CHK_W = 13;
	localparam int unsigned Q_W   = 21;
	localparam int unsigned CFG_AW = 3;
	localparam int unsigned CFG_DW = 13;
	localparam int unsigned IN_DW  = 48;
	localparam int unsigned OUT_DW = 96;

	localparam logic [SF_W-1:0] SF_ONE = 9'd256;

	typedef enum logic [CFG_AW-1:0] {
		CFG_MIN_THROTTLE       = 3'd0,
		CFG_MIN_ARMED_THROTTLE = 3'd1,
		CFG_MID_COMMAND        = 3'd2,
		CFG_EMA_WEIGHT         = 3'd3,
		CFG_MIN_CHECK          = 3'd4,
		CFG_MAX_CHECK          = 3'd5,
		CFG_MIN_COMMAND        = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic        [CH_W-1:0]  min_throttle;
		logic        [CH_W-1:0]  min_armed_throttle;
		logic        [CH_W-1:0]  mid_command;
		logic        [SF_W-1:0]  ema_weight;
		logic signed [CHK_W-1:0] min_check;
		logic signed [CHK_W-1:0] max_check;
		logic        [CH_W-1:0]  min_command;
	} cfg_t;

	typedef struct packed {
		logic armed;
		logic flying;
		logic safety;
	} flags_t;

	typedef struct packed {
		logic            cmd_valid;
		logic [CH_W-1:0] cmd_value;
		logic            calib;
		logic            zero_i;
	} decision_t;

	typedef struct packed {
		logic [CH_W-1:0] throttle;
		logic [CH_W-1:0] pitch;
		logic [CH_W-1:0] roll;
		logic [CH_W-1:0] yaw;
	} frame_t;

endpackage

>>> rtl/core/sac_ema.sv
module sac_ema import sac_pkg::*; (
	input  logic signed [Q_W-1:0]  f_prev,
	input  logic        [CH_W-1:0] raw,
	input  logic        [CH_W-1:0] mid,
	input  logic        [SF_W-1:0] alpha,
	output logic signed [Q_W-1:0]  f_next
);

	logic signed [CH_W:0]   cent;
	logic signed [Q_W:0]    diff;
	logic signed [SF_W:0]   alpha_s;
	logic signed [31:0]     prod;
	logic signed [31:0]     rnd;
	logic signed [23:0]     step;
	logic signed [24:0]     sum;

	// f' = f + floor(((c - f) * a + 128) / 256), same as the weighted form
	assign cent    = $signed({1'b0, raw}) - $signed({1'b0, mid});
	assign diff    = $signed({cent[CH_W], cent, 8'd0}) - $signed({f_prev[Q_W-1], f_prev});
	assign alpha_s = $signed({1'b0, alpha});
	assign prod    = 32'(diff) * 32'(alpha_s);
	assign rnd     = prod + 32'sd128;
	assign step    = rnd[31:8];
	assign sum     = $signed({{4{f_prev[Q_W-1]}}, f_prev}) + $signed({step[23], step});

	always_comb begin
		if (sum > 25'sd1048575) begin
			f_next = 21'sd1048575;
		end else if (sum < -25'sd1048576) begin
			f_next = -21'sd1048576;
		end else begin
			f_next = sum[Q_W-1:0];
		end
	end

endmodule

>>> rtl/core/sac_gesture.sv
module sac_gesture import sac_pkg::*; (
	input  cfg_t                   cfg,
	input  flags_t                 st,
	input  logic        [CH_W-1:0] thr,
	input  logic signed [Q_W-1:0]  pitch,
	input  logic signed [Q_W-1:0]  roll,
	input  logic signed [Q_W-1:0]  yaw,
	output flags_t                 st_next,
	output decision_t              dec
);

	logic signed [Q_W-1:0] lo;
	logic signed [Q_W-1:0] hi;
	logic thr_low, yaw_lo, yaw_hi;
	logic dis, cal, arm;
	logic armed1, fly1, armed2;

	assign lo      = $signed({cfg.min_check, 8'd0});
	assign hi      = $signed({cfg.max_check, 8'd0});
	assign thr_low = thr < cfg.min_throttle;
	assign yaw_lo  = yaw < lo;
	assign yaw_hi  = yaw > hi;

	// steps are ordered: arm sees the armed flag as left by disarm
	assign dis    = thr_low && yaw_lo && st.armed;
	assign armed1 = st.armed & ~dis;
	assign fly1   = st.flying & ~dis;
	assign cal    = thr_low && yaw_lo && (roll > hi) && (pitch < lo);
	assign arm    = thr_low && yaw_hi && !armed1 && st.safety;
	assign armed2 = armed1 | arm;

	assign st_next.armed  = armed2;
	assign st_next.flying = fly1 | (armed2 && (thr > cfg.min_armed_throttle));
	assign st_next.safety = st.safety | (thr_low && (yaw > lo));

	assign dec.cmd_valid = dis | arm;
	assign dec.cmd_value = arm ? cfg.min_throttle : (dis ? cfg.min_command : '0);
	assign dec.calib     = cal;
	assign dec.zero_i    = cal | arm;

endmodule

>>> rtl/core/stick_arming_controller.sv
// Stick arming controller.
// Input stream: one receiver frame per request (throttle, pitch, roll, yaw).
// Output stream: one result per frame, in order: motor command, calibration
// and integral-reset requests, armed and in-flight flags, passed-through
// throttle and the three smoothed centered sticks (signed Q13.8).
// Config port: cfg_we/cfg_addr/cfg_data writes one register per cycle; write
// only while no frame is in flight.
// Path: an accepted frame is held in the input register, its result in the
// result register. Throughput: one frame per cycle unless the output stalls.
// Filter state and arming flags are updated by a single pass (one multiplier
// per stick) between the two registers, so consecutive frames need no gap.
// Stall: the result register holds while m_axis_tready is low; the input
// register still takes one more frame, then s_axis_tready drops.
// Reset: filters and flags clear to zero (disarmed, on ground), registers
// take their default values, both stream sides empty.
module stick_arming_controller import sac_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	// [11:0] throttle_raw, [23:12] pitch_raw, [35:24] roll_raw, [47:36] yaw_raw
	input  logic [IN_DW-1:0]   s_axis_tdata,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// [0] motor_cmd_valid, [12:1] motor_cmd_value, [13] calibrate_request,
	// [14] zero_integral_request, [15] armed, [16] in_flight,
	// [28:17] throttle_out, [49:29] pitch_smoothed, [70:50] roll_smoothed,
	// [91:71] yaw_smoothed, [95:92] zero
	output logic [OUT_DW-1:0]  m_axis_tdata,
	input  logic               cfg_we,
	input  logic [CFG_AW-1:0]  cfg_addr,
	input  logic [CFG_DW-1:0]  cfg_data
);

	cfg_t   cfg_q;
	flags_t flags_q;
	flags_t flags_next;
	logic signed [Q_W-1:0] pitch_q, roll_q, yaw_q;
	logic signed [Q_W-1:0] pitch_next, roll_next, yaw_next;
	logic [SF_W-1:0] alpha;

	frame_t frame_s1;
	logic   valid_s1;
	logic   out_valid_q;
	logic   out_adv, move;
	decision_t dec;

	decision_t             dec_q;
	flags_t                oflags_q;
	logic [CH_W-1:0]       thr_q;
	logic signed [Q_W-1:0] pitch_o_q, roll_o_q, yaw_o_q;

	assign out_adv       = !out_valid_q || m_axis_tready;
	assign move          = valid_s1 && out_adv;
	assign s_axis_tready = !valid_s1 || out_adv;
	assign m_axis_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_throttle       <= 12'd1100;
			cfg_q.min_armed_throttle <= 12'd1150;
			cfg_q.mid_command        <= 12'd1500;
			cfg_q.ema_weight         <= 9'd128;
			cfg_q.min_check          <= -13'sd400;
			cfg_q.max_check          <= 13'sd400;
			cfg_q.min_command        <= 12'd1000;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_MIN_THROTTLE:       cfg_q.min_throttle       <= cfg_data[CH_W-1:0];
				CFG_MIN_ARMED_THROTTLE: cfg_q.min_armed_throttle <= cfg_data[CH_W-1:0];
				CFG_MID_COMMAND:        cfg_q.mid_command        <= cfg_data[CH_W-1:0];
				CFG_EMA_WEIGHT:         cfg_q.ema_weight         <= cfg_data[SF_W-1:0];
				CFG_MIN_CHECK:          cfg_q.min_check          <= $signed(cfg_data[CHK_W-1:0]);
				CFG_MAX_CHECK:          cfg_q.max_check          <= $signed(cfg_data[CHK_W-1:0]);
				CFG_MIN_COMMAND:        cfg_q.min_command        <= cfg_data[CH_W-1:0];
				default: ;
			endcase
		end
	end

	// anything with bit 8 set means full weight on the new sample
	assign alpha = cfg_q.ema_weight[SF_W-1] ? SF_ONE : cfg_q.ema_weight;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (out_adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			frame_s1.throttle <= s_axis_tdata[CH_W-1:0];
			frame_s1.pitch    <= s_axis_tdata[2*CH_W-1:CH_W];
			frame_s1.roll     <= s_axis_tdata[3*CH_W-1:2*CH_W];
			frame_s1.yaw      <= s_axis_tdata[4*CH_W-1:3*CH_W];
		end
	end

	sac_ema u_ema_pitch (
		.f_prev (pitch_q),
		.raw    (frame_s1.pitch),
		.mid    (cfg_q.mid_command),
		.alpha  (alpha),
		.f_next (pitch_next)
	);

	sac_ema u_ema_roll (
		.f_prev (roll_q),
		.raw    (frame_s1.roll),
		.mid    (cfg_q.mid_command),
		.alpha  (alpha),
		.f_next (roll_next)
	);

	sac_ema u_ema_yaw (
		.f_prev (yaw_q),
		.raw    (frame_s1.yaw),
		.mid    (cfg_q.mid_command),
		.alpha  (alpha),
		.f_next (yaw_next)
	);

	sac_gesture u_gesture (
		.cfg     (cfg_q),
		.st      (flags_q),
		.thr     (frame_s1.throttle),
		.pitch   (pitch_next),
		.roll    (roll_next),
		.yaw     (yaw_next),
		.st_next (flags_next),
		.dec     (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q <= '0;
			roll_q  <= '0;
			yaw_q   <= '0;
			flags_q <= '0;
		end else if (move) begin
			pitch_q <= pitch_next;
			roll_q  <= roll_next;
			yaw_q   <= yaw_next;
			flags_q <= flags_next;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			dec_q     <= dec;
			oflags_q  <= flags_next;
			thr_q     <= frame_s1.throttle;
			pitch_o_q <= pitch_next;
			roll_o_q  <= roll_next;
			yaw_o_q   <= yaw_next;
		end
	end

	assign m_axis_tdata = {4'd0, yaw_o_q, roll_o_q, pitch_o_q, thr_q,
		oflags_q.flying, oflags_q.armed, dec_q.zero_i, dec_q.calib,
		dec_q.cmd_value, dec_q.cmd_valid};

endmodule

>>> rtl/core/sac_checker.sv
`include "stick_arming_controller_defines.svh"

module sac_checker import sac_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              m_axis_tvalid,
	input logic              m_axis_tready,
	input logic [OUT_DW-1:0] m_axis_tdata
);

	// a stalled result holds
	`SAC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	// no motor command means a zero motor value
	`SAC_ASSERT_NOW(a_cmd_zero, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[12:1] == 12'd0)

	// in flight only while armed
	`SAC_ASSERT_NOW(a_fly_armed, m_axis_tvalid && m_axis_tdata[16], m_axis_tdata[15])

	// calibration always comes with an integral reset
	`SAC_ASSERT_NOW(a_cal_zero, m_axis_tvalid && m_axis_tdata[13], m_axis_tdata[14])

endmodule

bind stick_arming_controller sac_checker u_sac_checker (.*);
